// File: rtl/core/rip_route_table_engine_assert.svh
// Assertion macros for the route table engine, included by rte_dpath.
// Depends on the asserting module having aclk and aresetn in scope.
`ifndef RIP_ROUTE_TABLE_ENGINE_ASSERT_SVH
`define RIP_ROUTE_TABLE_ENGINE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define RTE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define RTE_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) else $error(msg);

`endif

// File: rtl/core/rte_pkg.sv
// Shared types and constants of the route table engine.
// Used by rte_ctrl, rte_dpath and rip_route_table_engine; depends on nothing.
package rte_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int METRIC_W    = 5;
    localparam int TOTAL_W     = 7;
    localparam int TIMEOUT_W   = 16;

    localparam logic [METRIC_W-1:0] METRIC_INF   = 5'd16;
    localparam logic [METRIC_W-1:0] LOCAL_METRIC = 5'd1;

    localparam logic [TIMEOUT_W-1:0] ROUTE_TO_RESET   = 16'd180;
    localparam logic [TIMEOUT_W-1:0] GARBAGE_TO_RESET = 16'd120;

    // Configuration register word indexes.
    localparam logic REG_ROUTE_TO   = 1'b0;
    localparam logic REG_GARBAGE_TO = 1'b1;

    typedef enum logic [1:0] {
        ACT_LEARN = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_LOCAL = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LK_RD,
        ST_LK_CMP,
        ST_COMMIT,
        ST_TICK,
        ST_SW_RD,
        ST_SW_WR,
        ST_SW_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [31:0]         network;
        logic [31:0]         mask;
        logic [31:0]         gateway;
        logic [METRIC_W-1:0] metric;
        logic                local_route;
        logic                poisoned;
        logic [31:0]         refresh_time;
        logic [31:0]         poison_time;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd;
        logic inc;
        logic mark_found;
        logic commit;
        logic tick;
        logic sw_wr;
        logic sw_fin;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;
        logic hit;
        logic out_free;
    } status_t;

endpackage

// File: rtl/core/rte_ctrl.sv
// Controller state machine of the route table engine.
// Depends on rte_pkg; drives rte_dpath through command and status structs.
module rte_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [1:0]       s_action,
    output logic             s_ready,
    input  rte_pkg::status_t status,
    output rte_pkg::cmd_t    cmd
);

    rte_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rte_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rte_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (rte_pkg::action_t'(s_action) == rte_pkg::ACT_TICK) begin
                        state_next = rte_pkg::ST_TICK;
                    end else begin
                        state_next = rte_pkg::ST_LK_RD;
                    end
                end
            end
            rte_pkg::ST_LK_RD: begin
                if (status.scan_end) begin
                    state_next = rte_pkg::ST_COMMIT;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = rte_pkg::ST_LK_CMP;
                end
            end
            rte_pkg::ST_LK_CMP: begin
                if (status.hit) begin
                    cmd.mark_found = 1'b1;
                    state_next     = rte_pkg::ST_COMMIT;
                end else begin
                    cmd.inc    = 1'b1;
                    state_next = rte_pkg::ST_LK_RD;
                end
            end
            rte_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = rte_pkg::ST_OUT;
            end
            rte_pkg::ST_TICK: begin
                cmd.tick   = 1'b1;
                state_next = rte_pkg::ST_SW_RD;
            end
            rte_pkg::ST_SW_RD: begin
                if (status.scan_end) begin
                    state_next = rte_pkg::ST_SW_FIN;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = rte_pkg::ST_SW_WR;
                end
            end
            rte_pkg::ST_SW_WR: begin
                cmd.sw_wr  = 1'b1;
                state_next = rte_pkg::ST_SW_RD;
            end
            rte_pkg::ST_SW_FIN: begin
                cmd.sw_fin = 1'b1;
                state_next = rte_pkg::ST_OUT;
            end
            rte_pkg::ST_OUT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = rte_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rte_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/rte_dpath.sv
// Datapath of the route table engine: route memory, scan pointers, clock,
// result registers. Depends on rte_pkg and the assertion macro header.
`include "rip_route_table_engine_assert.svh"

module rte_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rte_pkg::cmd_t                       cmd,
    output rte_pkg::status_t                    status,
    input  logic [rte_pkg::TIMEOUT_W-1:0]       route_to,
    input  logic [rte_pkg::TIMEOUT_W-1:0]       garbage_to,
    input  logic [1:0]                          s_action,
    input  logic [31:0]                         s_dest_network,
    input  logic [31:0]                         s_dest_mask,
    input  logic [31:0]                         s_advertised_next_hop,
    input  logic [rte_pkg::METRIC_W-1:0]        s_advertised_metric,
    input  logic [31:0]                         s_sender_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_table_changed,
    output logic                                m_route_found,
    output logic [rte_pkg::METRIC_W-1:0]        m_metric_out,
    output logic                                m_table_full,
    output logic [rte_pkg::TOTAL_W-1:0]         m_entry_total
);

    localparam int IDX_W = rte_pkg::IDX_W;
    localparam int CNT_W = rte_pkg::CNT_W;
    localparam int MW    = rte_pkg::METRIC_W;

    rte_pkg::entry_t mem [rte_pkg::TABLE_DEPTH];
    rte_pkg::entry_t rdata_reg;

    rte_pkg::action_t action_reg;
    logic [31:0]      net_reg, mask_reg, hop_reg, sender_reg;
    logic [MW-1:0]    adv_metric_reg;

    logic [CNT_W-1:0] count_reg, scan_reg, wptr_reg;
    logic [31:0]      seconds_reg;
    logic             found_reg;

    logic             res_changed_reg, res_found_reg, res_full_reg;
    logic [MW-1:0]    res_metric_reg;

    logic             m_valid_reg;

    // Item decode for learn and local add.
    logic             metric_ok, table_is_full;
    logic [MW-1:0]    learn_metric;
    logic [31:0]      hop_sel;

    logic             c_we, c_append, c_changed, c_full;
    logic [IDX_W-1:0] c_addr;
    rte_pkg::entry_t  c_data;
    logic [MW-1:0]    c_metric_out;

    logic             sw_del, sw_poison;
    rte_pkg::entry_t  sw_data;
    logic [31:0]      age_poison, age_refresh;

    logic             we;
    logic [IDX_W-1:0] waddr;
    rte_pkg::entry_t  wdata;

    assign metric_ok     = (adv_metric_reg >= 5'd1) && (adv_metric_reg <= rte_pkg::METRIC_INF);
    assign learn_metric  = (adv_metric_reg >= rte_pkg::METRIC_INF) ? rte_pkg::METRIC_INF
                                                                   : adv_metric_reg + 5'd1;
    assign hop_sel       = (hop_reg == 32'd0) ? sender_reg : hop_reg;
    assign table_is_full = count_reg >= CNT_W'(rte_pkg::TABLE_DEPTH);

    // Status back to the controller.
    assign status.scan_end = scan_reg >= count_reg;
    assign status.hit      = (rdata_reg.network == net_reg) && (rdata_reg.mask == mask_reg);
    assign status.out_free = !m_valid_reg || m_ready;

    // Update for learn, query and local add once the lookup is done.
    always_comb begin
        c_we         = 1'b0;
        c_append     = 1'b0;
        c_changed    = 1'b0;
        c_full       = 1'b0;
        c_addr       = scan_reg[IDX_W-1:0];
        c_data       = rdata_reg;
        c_metric_out = '0;
        case (action_reg)
            rte_pkg::ACT_LEARN: begin
                if (metric_ok) begin
                    if (!found_reg) begin
                        if (learn_metric != rte_pkg::METRIC_INF) begin
                            if (table_is_full) begin
                                c_full = 1'b1;
                            end else begin
                                c_append = 1'b1;
                            end
                        end
                        c_data.network      = net_reg;
                        c_data.mask         = mask_reg;
                        c_data.gateway      = hop_sel;
                        c_data.metric       = learn_metric;
                        c_data.local_route  = 1'b0;
                        c_data.poisoned     = 1'b0;
                        c_data.refresh_time = seconds_reg;
                        c_data.poison_time  = 32'd0;
                    end else if (!rdata_reg.local_route) begin
                        if (rdata_reg.gateway == hop_sel) begin
                            c_we                = 1'b1;
                            c_data.metric       = learn_metric;
                            c_data.refresh_time = seconds_reg;
                            if (rdata_reg.metric != learn_metric) begin
                                c_changed = 1'b1;
                                if (learn_metric == rte_pkg::METRIC_INF) begin
                                    c_data.poison_time = seconds_reg;
                                    c_data.poisoned    = 1'b1;
                                end
                            end
                            if (learn_metric != rte_pkg::METRIC_INF) begin
                                c_data.poisoned = 1'b0;
                            end
                        end else if (learn_metric < rdata_reg.metric) begin
                            c_we                = 1'b1;
                            c_changed           = 1'b1;
                            c_data.gateway      = hop_sel;
                            c_data.metric       = learn_metric;
                            c_data.refresh_time = seconds_reg;
                            c_data.poisoned     = 1'b0;
                        end
                    end
                end
            end
            rte_pkg::ACT_QUERY: begin
                c_metric_out = found_reg ? rdata_reg.metric : rte_pkg::METRIC_INF;
            end
            rte_pkg::ACT_LOCAL: begin
                if (table_is_full) begin
                    c_full = 1'b1;
                end else begin
                    c_append = 1'b1;
                end
                c_data.network      = net_reg;
                c_data.mask         = mask_reg;
                c_data.gateway      = 32'd0;
                c_data.metric       = rte_pkg::LOCAL_METRIC;
                c_data.local_route  = 1'b1;
                c_data.poisoned     = 1'b0;
                c_data.refresh_time = seconds_reg;
                c_data.poison_time  = 32'd0;
            end
            default: begin
            end
        endcase
        if (c_append) begin
            c_we      = 1'b1;
            c_changed = 1'b1;
            c_addr    = count_reg[IDX_W-1:0];
        end
    end

    // Sweep step: drop expired poisoned routes, poison stale ones, compact.
    always_comb begin
        age_poison  = seconds_reg - rdata_reg.poison_time;
        age_refresh = seconds_reg - rdata_reg.refresh_time;
        sw_del      = !rdata_reg.local_route && (rdata_reg.metric >= rte_pkg::METRIC_INF) &&
                      rdata_reg.poisoned && (age_poison >= {16'd0, garbage_to});
        sw_poison   = !rdata_reg.local_route && (rdata_reg.metric < rte_pkg::METRIC_INF) &&
                      (age_refresh >= {16'd0, route_to});
        sw_data     = rdata_reg;
        if (sw_poison) begin
            sw_data.metric      = rte_pkg::METRIC_INF;
            sw_data.poison_time = seconds_reg;
            sw_data.poisoned    = 1'b1;
        end
    end

    // Memory write port select.
    always_comb begin
        we    = 1'b0;
        waddr = c_addr;
        wdata = c_data;
        if (cmd.commit) begin
            we = c_we;
        end else if (cmd.sw_wr) begin
            we    = !sw_del;
            waddr = wptr_reg[IDX_W-1:0];
            wdata = sw_data;
        end
    end

    // Route memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[scan_reg[IDX_W-1:0]];
        end
    end

    // Captured item fields.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg     <= rte_pkg::action_t'(s_action);
            net_reg        <= s_dest_network;
            mask_reg       <= s_dest_mask;
            hop_reg        <= s_advertised_next_hop;
            adv_metric_reg <= s_advertised_metric;
            sender_reg     <= s_sender_address;
        end
    end

    // Control state: counts, pointers, clock, pending result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            scan_reg        <= '0;
            wptr_reg        <= '0;
            seconds_reg     <= '0;
            found_reg       <= 1'b0;
            res_changed_reg <= 1'b0;
            res_found_reg   <= 1'b0;
            res_full_reg    <= 1'b0;
            res_metric_reg  <= '0;
        end else begin
            if (cmd.load) begin
                scan_reg        <= '0;
                found_reg       <= 1'b0;
                res_changed_reg <= 1'b0;
                res_found_reg   <= 1'b0;
                res_full_reg    <= 1'b0;
                res_metric_reg  <= '0;
            end
            if (cmd.inc) begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.mark_found) begin
                found_reg <= 1'b1;
            end
            if (cmd.commit) begin
                res_changed_reg <= c_changed;
                res_found_reg   <= found_reg;
                res_full_reg    <= c_full;
                res_metric_reg  <= c_metric_out;
                if (c_append) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.tick) begin
                seconds_reg <= seconds_reg + 32'd1;
                scan_reg    <= '0;
                wptr_reg    <= '0;
            end
            if (cmd.sw_wr) begin
                scan_reg <= scan_reg + 1'b1;
                if (!sw_del) begin
                    wptr_reg <= wptr_reg + 1'b1;
                end
                if (sw_del || sw_poison) begin
                    res_changed_reg <= 1'b1;
                end
            end
            if (cmd.sw_fin) begin
                count_reg <= wptr_reg;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_table_changed <= res_changed_reg;
            m_route_found   <= res_found_reg;
            m_metric_out    <= res_metric_reg;
            m_table_full    <= res_full_reg;
            m_entry_total   <= rte_pkg::TOTAL_W'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;

    `RTE_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(rte_pkg::TABLE_DEPTH), "entry count over depth")
    `RTE_ASSERT_ALWAYS(a_wptr_behind, !cmd.sw_wr || (wptr_reg <= scan_reg), "sweep write ahead of read")
    `RTE_ASSERT_NEXT(a_emit_valid, cmd.emit, m_valid_reg, "emitted item not shown")
    `RTE_ASSERT_NEXT(a_append_grows, cmd.commit && c_append, count_reg == $past(count_reg) + 1'b1, "append lost")

endmodule

// File: rtl/core/rip_route_table_engine.sv
// Top level of the RIP route table engine: configuration registers and
// the controller and datapath. Depends on rte_pkg, rte_ctrl and rte_dpath.
//
// Usage: one item in on the s_ channel (valid/ready), one result out on the
// m_ channel (valid/ready) for every item. An item is taken only while the
// engine is idle; a result still waiting on m_ does not block acceptance.
// Learn, query and local add scan the table for the first entry matching
// network and mask, reading and then comparing each entry in turn, then
// update and emit; a full table holds 64 entries. A one-second tick rewrites
// the table in one compacting pass, reading each entry and writing back the
// kept ones in turn. The single memory read port paces both scans. If the
// receiver stalls, the finished result waits in the output register and the
// next result is held until it is taken. Synchronous reset empties the table,
// zeroes the seconds clock and loads the timeouts with 180 and 120 seconds;
// no clearing pass is needed.
// The APB port writes route timeout at 0x0 and garbage timeout at 0x4.
module rip_route_table_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [31:0]                  s_dest_network,
    input  logic [31:0]                  s_dest_mask,
    input  logic [31:0]                  s_advertised_next_hop,
    input  logic [rte_pkg::METRIC_W-1:0] s_advertised_metric,
    input  logic [31:0]                  s_sender_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_table_changed,
    output logic                         m_route_found,
    output logic [rte_pkg::METRIC_W-1:0] m_metric_out,
    output logic                         m_table_full,
    output logic [rte_pkg::TOTAL_W-1:0]  m_entry_total
);

    logic [rte_pkg::TIMEOUT_W-1:0] route_to_reg, garbage_to_reg;
    logic                          cfg_wr;
    rte_pkg::cmd_t                 cmd;
    rte_pkg::status_t              status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_to_reg   <= rte_pkg::ROUTE_TO_RESET;
            garbage_to_reg <= rte_pkg::GARBAGE_TO_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                rte_pkg::REG_ROUTE_TO:   route_to_reg   <= pwdata[rte_pkg::TIMEOUT_W-1:0];
                rte_pkg::REG_GARBAGE_TO: garbage_to_reg <= pwdata[rte_pkg::TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            rte_pkg::REG_ROUTE_TO:   prdata = {16'd0, route_to_reg};
            rte_pkg::REG_GARBAGE_TO: prdata = {16'd0, garbage_to_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    rte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rte_dpath u_dpath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .route_to              (route_to_reg),
        .garbage_to            (garbage_to_reg),
        .s_action              (s_action),
        .s_dest_network        (s_dest_network),
        .s_dest_mask           (s_dest_mask),
        .s_advertised_next_hop (s_advertised_next_hop),
        .s_advertised_metric   (s_advertised_metric),
        .s_sender_address      (s_sender_address),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_table_changed       (m_table_changed),
        .m_route_found         (m_route_found),
        .m_metric_out          (m_metric_out),
        .m_table_full          (m_table_full),
        .m_entry_total         (m_entry_total)
    );

endmodule
